[sv/slbl_pkg.sv]
// slbl_pkg: shared types and constants for the slew limited joint angle pose blend unit
// no dependencies; used by every module of the block
`default_nettype none

package slbl_pkg;

    localparam int unsigned POSE_DURATION_DEF = 16;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [31:0] FADE_BIAS = 32'd655;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POSE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] target_angle;
        logic signed [31:0] pose_angle;
        logic        [16:0] pose_weight;
        logic        [16:0] mask_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] angle;
        logic               changed;
    } t_out_item;

    typedef struct packed {
        logic tick;
        logic pose;
    } t_pose_ctrl;

    function automatic logic [16:0] clamp_weight(input logic [16:0] w);
        clamp_weight = (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

endpackage

`default_nettype wire

[sv/slbl_pose_state.sv]
// slbl_pose_state: pose offset, mask weight and hold count with the fade logic
// depends on slbl_pkg
`default_nettype none

module slbl_pose_state #(
    parameter int unsigned POSE_DURATION = slbl_pkg::POSE_DURATION_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slbl_pkg::t_pose_ctrl i_ctrl,
    input  wire logic signed [31:0]   i_pose_angle,
    input  wire logic        [16:0]   i_pose_weight,
    input  wire logic        [16:0]   i_mask_weight,
    output logic             [16:0]   o_tick_mask,
    output logic signed      [31:0]   o_tick_offset
);

    localparam int unsigned FADE_STEP   = 65536 / POSE_DURATION;
    localparam int unsigned FADE_FACTOR = 65536 - FADE_STEP;
    localparam logic [17:0] STEP_W      = 18'(FADE_STEP);
    localparam logic [16:0] FACTOR_W    = 17'(FADE_FACTOR);
    localparam logic [7:0]  HOLD_LOAD   = 8'(POSE_DURATION);

    logic        [16:0] r_mask;
    logic signed [31:0] r_offset;
    logic        [7:0]  r_hold;
    logic        [16:0] n_mask;
    logic signed [31:0] n_offset;
    logic        [7:0]  n_hold;

    logic        [17:0] mask_sum;
    logic        [16:0] mask_fade;
    logic        [47:0] fade_prod;
    logic        [31:0] fade_val;
    logic signed [31:0] offset_fade;
    logic               offset_pos;
    logic        [7:0]  tick_hold;
    logic        [16:0] pose_w;
    logic signed [49:0] pose_prod;

    always_comb begin
        mask_sum    = {1'b0, r_mask} + STEP_W;
        mask_fade   = (mask_sum > {1'b0, slbl_pkg::ONE_Q16}) ? slbl_pkg::ONE_Q16
                                                             : mask_sum[16:0];
        fade_prod   = 48'(r_offset[30:0]) * 48'(FACTOR_W);
        fade_val    = fade_prod[47:16];
        offset_fade = (fade_val > slbl_pkg::FADE_BIAS) ? $signed(fade_val - slbl_pkg::FADE_BIAS)
                                                       : 32'sd0;
        offset_pos  = !r_offset[31] && (r_offset != 32'sd0);

        o_tick_mask   = r_mask;
        o_tick_offset = r_offset;
        tick_hold     = r_hold;
        if (r_hold != 8'd0) begin
            tick_hold = r_hold - 8'd1;
        end else if ((r_mask < slbl_pkg::ONE_Q16) || offset_pos) begin
            o_tick_mask   = mask_fade;
            o_tick_offset = offset_pos ? offset_fade : 32'sd0;
        end
    end

    // product always fits 32 bits since the weight is at most one
    always_comb begin
        pose_w    = slbl_pkg::clamp_weight(i_pose_weight);
        pose_prod = i_pose_angle * $signed({1'b0, pose_w});
    end

    always_comb begin
        n_mask   = r_mask;
        n_offset = r_offset;
        n_hold   = r_hold;
        if (i_ctrl.pose) begin
            n_mask   = slbl_pkg::clamp_weight(i_mask_weight);
            n_offset = pose_prod[47:16];
            n_hold   = HOLD_LOAD;
        end else if (i_ctrl.tick) begin
            n_mask   = o_tick_mask;
            n_offset = o_tick_offset;
            n_hold   = tick_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= slbl_pkg::ONE_Q16;
            r_offset <= 32'sd0;
            r_hold   <= 8'd0;
        end else begin
            r_mask   <= n_mask;
            r_offset <= n_offset;
            r_hold   <= n_hold;
        end
    end

endmodule

`default_nettype wire

[sv/slbl_track.sv]
// slbl_track: slew limit, mask blend, saturation and the current angle register
// depends on slbl_pkg
`default_nettype none

module slbl_track (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slbl_pkg::t_pose_ctrl i_ctrl,
    input  wire logic signed [31:0]   i_target_angle,
    input  wire logic        [30:0]   i_max_step,
    input  wire logic        [16:0]   i_mask,
    input  wire logic signed [31:0]   i_offset,
    output slbl_pkg::t_out_item       o_result
);

    logic signed [31:0] r_angle;
    logic signed [31:0] n_angle;

    logic signed [32:0] delta;
    logic        [32:0] mag;
    logic signed [32:0] step_up;
    logic signed [32:0] step_dn;
    logic signed [31:0] scripted;
    logic signed [49:0] blend_prod;
    logic signed [33:0] blended;
    logic signed [31:0] sat_angle;

    always_comb begin
        delta   = {i_target_angle[31], i_target_angle} - {r_angle[31], r_angle};
        mag     = delta[32] ? 33'(-delta) : 33'(delta);
        step_up = {r_angle[31], r_angle} + $signed({2'b00, i_max_step});
        step_dn = {r_angle[31], r_angle} - $signed({2'b00, i_max_step});
        // a limited step never passes the target, so 32 bits hold it
        if (mag < {2'b00, i_max_step}) begin
            scripted = i_target_angle;
        end else if (!delta[32] && (delta != 33'sd0)) begin
            scripted = step_up[31:0];
        end else begin
            scripted = step_dn[31:0];
        end

        blend_prod = scripted * $signed({1'b0, i_mask});
        blended    = blend_prod[49:16] + {{2{i_offset[31]}}, i_offset};
        if (blended[33:31] == 3'b000 || blended[33:31] == 3'b111) begin
            sat_angle = blended[31:0];
        end else if (blended[33]) begin
            sat_angle = 32'sh8000_0000;
        end else begin
            sat_angle = 32'sh7FFF_FFFF;
        end

        n_angle          = r_angle;
        o_result.angle   = r_angle;
        o_result.changed = 1'b0;
        if (i_ctrl.tick) begin
            n_angle          = sat_angle;
            o_result.angle   = sat_angle;
            o_result.changed = (sat_angle != r_angle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= 32'sd0;
        end else begin
            r_angle <= n_angle;
        end
    end

endmodule

`default_nettype wire

[sv/slew_limited_joint_angle_pose_blend_unit.sv]
// slew_limited_joint_angle_pose_blend_unit: top level, handshakes, input and result registers
// depends on slbl_pkg, slbl_pose_state and slbl_track
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   in       | input     | i_in_valid / o_in_ready   | i_in_item  (slbl_pkg::t_in_item)
//   out      | output    | o_out_valid / i_out_ready | o_out_item (slbl_pkg::t_out_item)
//   cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (max_step, 31 bits)
//
// one item per cycle sustained unless the result stalls; from accept to result valid
// the item sits in the input register, then one combinational pass through the
// slew, fade and blend logic updates the state and loads the result register
// synchronous active low reset; no clearing pass, ready right after reset
// a stalled result holds while one more item waits in the input register
`default_nettype none

module slew_limited_joint_angle_pose_blend_unit #(
    parameter int unsigned POSE_DURATION = slbl_pkg::POSE_DURATION_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire slbl_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output slbl_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic         [30:0] i_cfg_data
);

    logic                r_in_valid;
    logic                n_in_valid;
    slbl_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    logic                n_out_valid;
    slbl_pkg::t_out_item r_out_item;
    logic         [30:0] r_max_step;

    logic                advance;
    slbl_pkg::t_pose_ctrl ctrl;
    logic         [16:0] tick_mask;
    logic signed  [31:0] tick_offset;
    slbl_pkg::t_out_item result;

    always_comb begin
        advance     = r_in_valid && (!r_out_valid || i_out_ready);
        o_in_ready  = !r_in_valid || advance;
        ctrl.tick   = advance && (r_in_item.cmd == slbl_pkg::CMD_TICK);
        ctrl.pose   = advance && (r_in_item.cmd == slbl_pkg::CMD_POSE);
        n_in_valid  = (i_in_valid && o_in_ready) ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
        o_cfg_ready = 1'b1;
    end

    slbl_pose_state #(
        .POSE_DURATION (POSE_DURATION)
    ) u_pose_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_pose_angle  (r_in_item.pose_angle),
        .i_pose_weight (r_in_item.pose_weight),
        .i_mask_weight (r_in_item.mask_weight),
        .o_tick_mask   (tick_mask),
        .o_tick_offset (tick_offset)
    );

    slbl_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_target_angle (r_in_item.target_angle),
        .i_max_step     (r_max_step),
        .i_mask         (tick_mask),
        .i_offset       (tick_offset),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_step  <= 31'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_step <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

endmodule

`default_nettype wire

[sv/slbl_checker.sv]
// slbl_checker: port level checks for the pose blend unit, bound to the top level
// depends on slbl_pkg and slew_limited_joint_angle_pose_blend_unit
`default_nettype none

module slbl_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire slbl_pkg::t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // input side only stalls behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    // an accepted item shows a valid result once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 1'b1 |=> o_out_valid)
        else $error("accepted item produced no result");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind slew_limited_joint_angle_pose_blend_unit slbl_checker u_slbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
